// ----- rtl/core/substr_pkg.sv -----
// substr_pkg: shared types and constants for the substring search block
// used by substr_cell, substr_track and substring_search; no dependencies

package substr_pkg;

	// fixed widths of the configuration registers and stream fields
	localparam int PATTERN_W   = 64;
	localparam int LEN_W       = 4;
	localparam int OFFSET_W    = 16;
	localparam int MATCH_POS_W = 16;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_START_OFFSET   = 2'd2,
		CFG_SEARCH_LAST    = 2'd3
	} cfg_index_t;

	// one accepted input transaction as seen by the match tracker
	typedef struct packed {
		logic accept;
		logic last;
		logic hit;
	} item_t;

endpackage

// ----- rtl/core/substr_cell.sv -----
// substr_cell: one window byte of the search chain with its pattern compare
// depends on substr_pkg

module substr_cell import substr_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic                 clear,
	input  logic [BYTE_W-1:0]    din,
	input  logic [PATTERN_W-1:0] pattern,
	input  logic [LEN_W-1:0]     len,
	output logic [BYTE_W-1:0]    dout,
	output logic                 hit
);

	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0]  sel;
	logic [BYTE_W-1:0] want;

	// pattern byte that lines up with this window slot
	assign sel  = len - LEN_W'(IDX) - LEN_W'(1);
	assign want = pattern[{sel[2:0], 3'b000} +: BYTE_W];

	// slots beyond the pattern length always agree
	assign hit = (LEN_W'(IDX) >= len) || (din == want);

	// window byte handed to the next slot per transaction, zeroed on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= clear ? '0 : din;
		end
	end

	assign dout = byte_q;

endmodule

// ----- rtl/core/substr_track.sv -----
// substr_track: position counter, match bookkeeping and result register
// depends on substr_pkg

module substr_track import substr_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  item_t                  item,
	input  logic [LEN_W-1:0]       len,
	input  logic [OFFSET_W-1:0]    start_offset,
	input  logic                   search_last,
	input  logic                   out_ready,
	output logic                   in_ready,
	output logic                   out_valid,
	output logic                   out_found,
	output logic [MATCH_POS_W-1:0] out_position
);

	localparam int CW = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

	logic [POSITION_BITS-1:0]  pos_q;
	logic                      seen_q;
	logic [POSITION_BITS-1:0]  best_q;
	logic                      valid_q;
	logic                      found_q;
	logic [MATCH_POS_W-1:0]    opos_q;

	logic [POSITION_BITS:0]    pos_inc;
	logic [POSITION_BITS:0]    start_w;
	logic                      window_full;
	logic                      counted;
	logic                      seen_next;
	logic [POSITION_BITS-1:0]  best_next;
	logic [POSITION_BITS+MATCH_POS_W-1:0] best_ext;

	// start of the candidate match ending at this byte
	assign pos_inc     = {1'b0, pos_q} + (POSITION_BITS+1)'(1);
	assign window_full = pos_inc >= (POSITION_BITS+1)'(len);
	assign start_w     = pos_inc - (POSITION_BITS+1)'(len);
	assign counted     = item.hit && window_full &&
		(CW'(start_w[POSITION_BITS-1:0]) >= CW'(start_offset));

	// first or last match bookkeeping
	always_comb begin
		seen_next = seen_q;
		best_next = best_q;
		if (counted) begin
			if (search_last || !seen_q) begin
				best_next = start_w[POSITION_BITS-1:0];
			end
			seen_next = 1'b1;
		end
	end

	assign best_ext = {{MATCH_POS_W{1'b0}}, best_next};

	// string state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= 1'b0;
			best_q <= '0;
		end else if (item.accept) begin
			if (item.last) begin
				pos_q  <= '0;
				seen_q <= 1'b0;
				best_q <= '0;
			end else begin
				if (pos_q != {POSITION_BITS{1'b1}}) begin
					pos_q <= pos_inc[POSITION_BITS-1:0];
				end
				seen_q <= seen_next;
				best_q <= best_next;
			end
		end
	end

	// result register toward the master side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			found_q <= 1'b0;
			opos_q  <= '0;
		end else if (item.accept && item.last) begin
			valid_q <= 1'b1;
			found_q <= seen_next;
			opos_q  <= seen_next ? best_ext[MATCH_POS_W-1:0] : '0;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign in_ready     = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign out_found    = found_q;
	assign out_position = opos_q;

	// a final byte always produces a result in the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item.accept && item.last |=> valid_q)
		else $error("final byte produced no result");

	// string state restarts after the final byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item.accept && item.last |=> (pos_q == '0) && !seen_q)
		else $error("string state not cleared");

	// no match means a zero position
	a_nofound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !found_q |-> (opos_q == '0))
		else $error("position set without a match");

	// no new transaction while a result is stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// a stored match never lies beyond the current position
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (best_q <= pos_q))
		else $error("match start beyond position");

endmodule

// ----- rtl/core/substring_search.sv -----
// substring_search: top level of the streaming substring search
// depends on substr_pkg, substr_cell and substr_track
//
// The searched string arrives on the slave stream, one byte per transaction,
// with s_axis_tlast on its final byte. A row of window cells shifts the byte
// in and each cell compares its slot with the aligned pattern byte; the
// tracker counts positions and keeps the first or last counted match.
// One result leaves on the master stream per string: m_axis_tuser is the
// found flag, m_axis_tdata the start position (zero when not found).
// Throughput: one byte per cycle unless a result stalls. The result is valid
// in the cycle after the final byte is accepted. The output register lets
// input flow on while the master side takes the result; while a result
// waits and m_axis_tready is low, s_axis_tready is low. Reset clears the
// window, the counters, the result register and loads the register reset
// values (pattern length 1). Configuration writes take effect the next cycle
// and are made while idle by the user; the block does not enforce it.

module substring_search import substr_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int POSITION_BITS     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] char_byte
	input  logic                   s_axis_tlast,   // end_of_string
	// master stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [MATCH_POS_W-1:0] m_axis_tdata,   // [15:0] match_position
	output logic                   m_axis_tuser,   // [0] found
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [PATTERN_W-1:0]   cfg_data
);

	logic [PATTERN_W-1:0] pattern_q;
	logic [LEN_W-1:0]     length_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic                 last_mode_q;

	logic [LEN_W-1:0]     len_used;
	logic                 accept;
	logic                 in_ready;
	item_t                item;

	logic [BYTE_W-1:0]    chain [MAX_PATTERN_BYTES+1];
	logic [MAX_PATTERN_BYTES-1:0] hits;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= '0;
			length_q    <= LEN_W'(1);
			offset_q    <= '0;
			last_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_BYTES:  pattern_q   <= cfg_data;
				CFG_PATTERN_LENGTH: length_q    <= cfg_data[LEN_W-1:0];
				CFG_START_OFFSET:   offset_q    <= cfg_data[OFFSET_W-1:0];
				CFG_SEARCH_LAST:    last_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pattern length clamped to the window size, zero used as one
	always_comb begin
		len_used = length_q;
		if (length_q == '0) begin
			len_used = LEN_W'(1);
		end else if (length_q > LEN_W'(MAX_PATTERN_BYTES)) begin
			len_used = LEN_W'(MAX_PATTERN_BYTES);
		end
	end

	assign accept = s_axis_tvalid && in_ready;

	// window chain, newest byte enters at slot zero
	assign chain[0] = s_axis_tdata;

	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_window
		substr_cell #(
			.IDX(j)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (accept),
			.clear   (s_axis_tlast),
			.din     (chain[j]),
			.pattern (pattern_q),
			.len     (len_used),
			.dout    (chain[j+1]),
			.hit     (hits[j])
		);
	end

	assign item.accept = accept;
	assign item.last   = s_axis_tlast;
	assign item.hit    = &hits;

	// position counting, match choice and result register
	substr_track #(
		.POSITION_BITS(POSITION_BITS)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.len          (len_used),
		.start_offset (offset_q),
		.search_last  (last_mode_q),
		.out_ready    (m_axis_tready),
		.in_ready     (in_ready),
		.out_valid    (m_axis_tvalid),
		.out_found    (m_axis_tuser),
		.out_position (m_axis_tdata)
	);

	assign s_axis_tready = in_ready;

endmodule

// ----- tb/substring_search_test.sv -----
// substring_search_test: self-checking bench for the streaming substring search
// depends on substr_pkg and substring_search; predicts each string's result and
// compares it with the master stream under random bursts and back-pressure

module substring_search_test;
	import substr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BYTES     = 8;
	localparam int RANDOM_TARGET = 1550;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 3;

	// one byte of searched text and its end mark
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              eos;
	} text_byte_t;

	// one per-string search report
	typedef struct packed {
		logic                   found;
		logic [MATCH_POS_W-1:0] position;
	} search_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata = '0;    // [7:0] char_byte
	logic                   s_axis_tlast = 1'b0;  // end_of_string
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [MATCH_POS_W-1:0] m_axis_tdata;         // [15:0] match_position
	logic                   m_axis_tuser;         // [0] found
	logic                   cfg_we = 1'b0;
	cfg_index_t             cfg_index = CFG_PATTERN_BYTES;
	logic [PATTERN_W-1:0]   cfg_data = '0;

	substring_search uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// mirrored register settings
	logic [PATTERN_W-1:0]   pat_bytes = '0;
	logic [LEN_W-1:0]       pat_len = 4'd1;
	logic [OFFSET_W-1:0]    start_off = '0;
	logic                   find_last = 1'b0;

	// predicted per-string search state
	logic [BYTE_W-1:0]      text_window [MAX_BYTES];
	logic [15:0]            next_index = '0;
	logic                   match_seen = 1'b0;
	logic [15:0]            reported_start = '0;

	text_byte_t     queued_text [$];
	logic [BYTE_W-1:0] text_buf [$];
	search_report_t predicted_reports [$];

	int error_count = 0;
	int strings_checked = 0;
	int strings_found = 0;
	int bytes_sent = 0;
	int cfg_writes = 0;
	int random_items = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;

	initial begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			text_window[i] = '0;
		end
	end

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// pattern length as the block uses it
	function automatic int used_len();
		if (pat_len == 0)
			return 1;
		if (pat_len > MAX_BYTES)
			return MAX_BYTES;
		return int'(pat_len);
	endfunction

	// shift one byte into the window, judge the match ending here, report at string end
	task automatic advance_search(input logic [BYTE_W-1:0] ch, input logic eos);
		int len;
		int start_idx;
		int i;
		logic hit;
		search_report_t rep;
		len = used_len();
		for (i = MAX_BYTES - 1; i > 0; i--) begin
			text_window[i] = text_window[i-1];
		end
		text_window[0] = ch;
		if (int'(next_index) + 1 >= len) begin
			start_idx = int'(next_index) + 1 - len;
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				if (text_window[len-1-i] != pat_bytes[8*i +: 8])
					hit = 1'b0;
			end
			if (hit && start_idx >= int'(start_off)) begin
				if (find_last || !match_seen)
					reported_start = start_idx[15:0];
				match_seen = 1'b1;
			end
		end
		// index sticks at its maximum on very long strings
		if (next_index != 16'hFFFF)
			next_index = next_index + 16'd1;
		if (eos) begin
			rep.found = match_seen;
			rep.position = match_seen ? reported_start : '0;
			predicted_reports.push_back(rep);
			for (i = 0; i < MAX_BYTES; i++) begin
				text_window[i] = '0;
			end
			next_index = '0;
			match_seen = 1'b0;
			reported_start = '0;
		end
	endtask

	// stream driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : stream_driver
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_search(s_axis_tdata, s_axis_tlast);
				void'(queued_text.pop_front());
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (queued_text.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= queued_text[0].ch;
					s_axis_tlast <= queued_text[0].eos;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(40, 200) : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor: check each transaction, then pick the next ready value
	always @(posedge clk or negedge arst_n) begin : report_monitor
		search_report_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_reports.size() == 0) begin
					$error("unexpected result: found %0d, match_position %0d",
						m_axis_tuser, m_axis_tdata);
					error_count++;
				end else begin
					want = predicted_reports.pop_front();
					strings_checked++;
					if (want.found)
						strings_found++;
					if (m_axis_tuser !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, m_axis_tuser);
						error_count++;
					end
					if (m_axis_tdata !== want.position) begin
						$error("match_position: expected %0d, got %0d",
							want.position, m_axis_tdata);
						error_count++;
					end
				end
			end
			// stall pattern switches between always ready, coin toss and mostly stalled
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 150);
			end
			mode_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL substring_search");
				$finish;
			end
		end
	end

	// wait until the text queue is sent and every report is back
	task automatic settle();
		do
			@(posedge clk);
		while (queued_text.size() != 0 || s_axis_tvalid || predicted_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [PATTERN_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_PATTERN_BYTES:  pat_bytes = value;
			CFG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
			CFG_START_OFFSET:   start_off = value[OFFSET_W-1:0];
			CFG_SEARCH_LAST:    find_last = value[0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [PATTERN_W-1:0] pattern, input int len,
		input int offset, input bit last_mode);
		settle();
		write_reg(CFG_PATTERN_BYTES, pattern);
		write_reg(CFG_PATTERN_LENGTH, PATTERN_W'(len));
		write_reg(CFG_START_OFFSET, PATTERN_W'(offset));
		write_reg(CFG_SEARCH_LAST, PATTERN_W'(last_mode));
		@(posedge clk);
	endtask

	// move the staged text into the send queue, optionally marking its end
	task automatic queue_text(input bit terminate);
		text_byte_t tb_byte;
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			tb_byte.ch = text_buf[i];
			tb_byte.eos = terminate && (i == n - 1);
			queued_text.push_back(tb_byte);
		end
		text_buf.delete();
	endtask

	function automatic logic [BYTE_W-1:0] corner_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			default: return 8'hA5;
		endcase
	endfunction

	// random string, mostly seeded with whole or cut copies of the pattern
	task automatic build_string();
		int len;
		int copies;
		int at;
		int plen;
		bit noise;
		plen = used_len();
		noise = ($urandom_range(0, 9) == 0);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 20);
		for (int i = 0; i < len; i++) begin
			if (noise)
				text_buf.push_back(BYTE_W'($urandom));
			else
				case ($urandom_range(0, 3))
					0, 1: text_buf.push_back(pat_bytes[8*$urandom_range(0, plen-1) +: 8]);
					2: text_buf.push_back(corner_byte());
					default: text_buf.push_back(BYTE_W'($urandom));
				endcase
		end
		if (!noise && $urandom_range(0, 9) < 7) begin
			copies = $urandom_range(1, 3);
			for (int c = 0; c < copies; c++) begin
				at = $urandom_range(0, len - 1);
				for (int k = 0; k < plen && at + k < len; k++) begin
					text_buf[at+k] = pat_bytes[8*k +: 8];
				end
			end
		end
		random_items += len;
	endtask

	// stimulus
	initial begin
		logic [PATTERN_W-1:0] pattern;
		int len;
		int offset;
		int strings;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single zero byte pattern, zero byte matches at position zero
		text_buf.push_back(8'h00);
		queue_text(1);
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h01);
		queue_text(1);

		// all-ones pattern of full length, two overlapping matches, first reported
		configure('1, MAX_BYTES, 0, 1'b0);
		repeat (9) text_buf.push_back(8'hFF);
		queue_text(1);

		// length above range is clamped to eight
		configure(64'h0123_4567_89AB_CDEF, 15, 0, 1'b0);
		for (int i = 0; i < MAX_BYTES; i++) begin
			text_buf.push_back(pat_bytes[8*i +: 8]);
		end
		queue_text(1);

		// zero length used as one, offset skips early matches, last match reported
		configure('0, 0, 3, 1'b1);
		repeat (5) text_buf.push_back(8'h00);
		queue_text(1);

		// offset beyond the string
		configure('0, 1, 16'hFFFF, 1'b0);
		text_buf.push_back(8'h00);
		queue_text(1);

		// report mode flipped to last in the middle of a string
		configure(64'h41, 1, 0, 1'b0);
		text_buf.push_back(8'h41);
		text_buf.push_back(8'h41);
		queue_text(0);
		settle();
		write_reg(CFG_SEARCH_LAST, PATTERN_W'(1));
		@(posedge clk);
		text_buf.push_back(8'h20);
		text_buf.push_back(8'h41);
		queue_text(1);

		// random settings, each followed by a batch of strings
		while (random_items < RANDOM_TARGET) begin
			if ($urandom_range(0, 1))
				for (int b = 0; b < MAX_BYTES; b++) begin
					pattern[8*b +: 8] = corner_byte();
				end
			else
				pattern = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = $urandom_range(9, 15);
				default: len = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: offset = 0;
				6, 7, 8: offset = $urandom_range(0, 16);
				default: offset = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
			endcase
			configure(pattern, len, offset, $urandom_range(0, 1));
			strings = $urandom_range(3, 12);
			for (int s = 0; s < strings; s++) begin
				build_string();
				queue_text(1);
				if ($urandom_range(0, 19) == 0)
					settle();
			end
		end

		settle();
		$display("checked %0d strings (%0d with a counted match) over %0d bytes",
			strings_checked, strings_found, bytes_sent);
		$display("%0d register writes: clamped lengths, offsets up to the top, both report modes",
			cfg_writes);
		if (error_count == 0)
			$display("PASS substring_search");
		else
			$display("FAIL substring_search");
		$finish;
	end

endmodule
